@@ hdl/flac_mbp_pkg.sv @@
// Shared types and constants for the FLAC metadata block parser.
// No dependencies; imported by every module of the block.
package flac_mbp_pkg;

    localparam int OFFSET_WIDTH_DEFAULT = 32;

    localparam logic [31:0] FLAC_MAGIC     = 32'h664C_6143;
    localparam logic [6:0]  TYPE_STREAMINFO = 7'd0;
    localparam logic [6:0]  TYPE_PICTURE    = 7'd6;
    localparam logic [23:0] STREAMINFO_LEN  = 24'd34;
    localparam logic [23:0] PICTURE_MIN_LEN = 24'd32;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_BAD_SINFO = 2'd2;
    localparam logic [1:0] STATUS_EARLY_END = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] rate_hz;
        logic [3:0]  channel_count;
        logic [5:0]  sample_bits;
        logic [35:0] total_samples;
        logic        picture_present;
        logic [31:0] picture_width;
        logic [31:0] picture_height;
        logic [31:0] picture_length;
        logic [31:0] picture_offset;
    } result_t;

endpackage

@@ hdl/flac_mbp_in_stage.sv @@
// Input register of the FLAC metadata parser: holds one stream word.
// Depends on flac_mbp_pkg.
module flac_mbp_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  flac_mbp_pkg::in_word_t in_word,
    output logic                   held_valid,
    output flac_mbp_pkg::in_word_t held_word,
    input  logic                   advance
);
    import flac_mbp_pkg::*;

    logic     valid_reg;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

@@ hdl/flac_mbp_core.sv @@
// Parser state and combinational next-state logic of the FLAC metadata parser.
// Depends on flac_mbp_pkg.
module flac_mbp_core #(
    parameter int OFFSET_WIDTH = flac_mbp_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  flac_mbp_pkg::in_word_t word,
    output logic                   res_valid,
    output flac_mbp_pkg::result_t  res
);
    import flac_mbp_pkg::*;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_HEADER, PH_STREAM, PH_SKIP, PH_PTYPE, PH_MIMELEN,
        PH_MIMESKIP, PH_DESCLEN, PH_DESCSKIP, PH_PFIELDS, PH_DONE
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [5:0]              fbi_reg, fbi_next;
    logic [23:0]             bbl_reg, bbl_next;
    logic                    last_reg, last_next;
    logic [6:0]              btype_reg, btype_next;
    logic [1:0]              kinds_reg, kinds_next;
    logic [31:0]             la_reg, la_next;
    logic [31:0]             skip_reg, skip_next;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [63:0]             si_reg, si_next;
    logic [63:0]             pic0_reg, pic0_next;
    logic [63:0]             pic1_reg, pic1_next;

    logic [31:0] la_shift;
    logic [5:0]  fbi_inc;
    logic [23:0] bbl_dec;
    logic [31:0] skip_dec;
    logic [31:0] off_sat;
    logic        block_end;
    logic        emit;
    logic [1:0]  emit_status;

    assign la_shift = {la_reg[23:0], word.data_byte};
    assign fbi_inc  = fbi_reg + 6'd1;
    assign bbl_dec  = bbl_reg - 24'd1;
    assign skip_dec = skip_reg - 32'd1;

    // Clamp the stream position to 32 bits for the picture offset.
    generate
        if (OFFSET_WIDTH > 32)
        begin : g_wide_pos
            assign off_sat = (|pos_next[OFFSET_WIDTH-1:32]) ? '1 : pos_next[31:0];
        end
        else
        begin : g_narrow_pos
            assign off_sat = 32'(pos_next);
        end
    endgenerate

    always_comb
    begin
        phase_next  = phase_reg;
        fbi_next    = fbi_reg;
        bbl_next    = bbl_reg;
        last_next   = last_reg;
        btype_next  = btype_reg;
        kinds_next  = kinds_reg;
        la_next     = la_reg;
        skip_next   = skip_reg;
        pos_next    = pos_reg;
        si_next     = si_reg;
        pic0_next   = pic0_reg;
        pic1_next   = pic1_reg;
        block_end   = 1'b0;
        emit        = 1'b0;
        emit_status = STATUS_OK;

        if (word.end_of_stream)
        begin
            if (phase_reg != PH_DONE)
            begin
                emit        = 1'b1;
                emit_status = STATUS_EARLY_END;
            end
            phase_next = PH_MAGIC;
            fbi_next   = '0;
            bbl_next   = '0;
            last_next  = 1'b0;
            btype_next = '0;
            kinds_next = '0;
            la_next    = '0;
            skip_next  = '0;
            pos_next   = '0;
            si_next    = '0;
            pic0_next  = '0;
            pic1_next  = '0;
        end
        else if (phase_reg != PH_DONE)
        begin
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + 1'b1;
            end
            case (phase_reg)
                PH_MAGIC:
                begin
                    la_next  = la_shift;
                    fbi_next = fbi_inc;
                    if (fbi_inc >= 6'd4)
                    begin
                        fbi_next = '0;
                        if (la_shift != FLAC_MAGIC)
                        begin
                            phase_next  = PH_DONE;
                            emit        = 1'b1;
                            emit_status = STATUS_BAD_MAGIC;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                PH_HEADER:
                begin
                    if (fbi_reg == 6'd0)
                    begin
                        last_next  = word.data_byte[7];
                        btype_next = word.data_byte[6:0];
                        la_next    = '0;
                        fbi_next   = 6'd1;
                    end
                    else
                    begin
                        la_next  = la_shift;
                        fbi_next = fbi_inc;
                        if (fbi_inc >= 6'd4)
                        begin
                            fbi_next   = '0;
                            bbl_next   = la_shift[23:0];
                            phase_next = PH_SKIP;
                            if (btype_reg == TYPE_STREAMINFO && !kinds_reg[0])
                            begin
                                kinds_next[0] = 1'b1;
                                if (la_shift[23:0] != STREAMINFO_LEN)
                                begin
                                    phase_next  = PH_DONE;
                                    emit        = 1'b1;
                                    emit_status = STATUS_BAD_SINFO;
                                end
                                else
                                begin
                                    phase_next = PH_STREAM;
                                end
                            end
                            else if (btype_reg == TYPE_PICTURE && !kinds_reg[1])
                            begin
                                kinds_next[1] = 1'b1;
                                if (la_shift[23:0] >= PICTURE_MIN_LEN)
                                begin
                                    phase_next = PH_PTYPE;
                                end
                            end
                            block_end = (la_shift[23:0] == '0) && !emit;
                        end
                    end
                end
                default:
                begin
                    // Byte inside a block body.
                    bbl_next  = bbl_dec;
                    block_end = (bbl_dec == '0);
                    case (phase_reg)
                        PH_STREAM:
                        begin
                            if (fbi_reg inside {[6'd10:6'd17]})
                            begin
                                si_next = {si_reg[55:0], word.data_byte};
                            end
                            if (fbi_reg < 6'd63)
                            begin
                                fbi_next = fbi_inc;
                            end
                        end
                        PH_PTYPE:
                        begin
                            fbi_next = fbi_inc;
                            if (fbi_inc >= 6'd4)
                            begin
                                phase_next = PH_MIMELEN;
                                fbi_next   = '0;
                                la_next    = '0;
                            end
                        end
                        PH_MIMELEN, PH_DESCLEN:
                        begin
                            la_next  = la_shift;
                            fbi_next = fbi_inc;
                            if (fbi_inc >= 6'd4)
                            begin
                                skip_next = la_shift;
                                fbi_next  = '0;
                                if (la_shift != '0)
                                begin
                                    phase_next = (phase_reg == PH_MIMELEN) ?
                                                 PH_MIMESKIP : PH_DESCSKIP;
                                end
                                else
                                begin
                                    la_next    = '0;
                                    phase_next = (phase_reg == PH_MIMELEN) ?
                                                 PH_DESCLEN : PH_PFIELDS;
                                end
                            end
                        end
                        PH_MIMESKIP, PH_DESCSKIP:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == '0)
                            begin
                                fbi_next   = '0;
                                la_next    = '0;
                                phase_next = (phase_reg == PH_MIMESKIP) ?
                                             PH_DESCLEN : PH_PFIELDS;
                            end
                        end
                        PH_PFIELDS:
                        begin
                            la_next  = la_shift;
                            fbi_next = fbi_inc;
                            if (fbi_inc == 6'd4)
                            begin
                                pic0_next = {la_shift, 32'd0};
                            end
                            else if (fbi_inc == 6'd8)
                            begin
                                pic0_next = {pic0_reg[63:32], pic0_reg[31:0] | la_shift};
                            end
                            else if (fbi_inc >= 6'd20)
                            begin
                                pic1_next  = {la_shift, off_sat};
                                phase_next = PH_SKIP;
                                fbi_next   = '0;
                            end
                        end
                        default:
                        begin
                            // Skip: count only.
                        end
                    endcase
                end
            endcase

            if (block_end)
            begin
                fbi_next = '0;
                if (last_reg)
                begin
                    phase_next  = PH_DONE;
                    emit        = 1'b1;
                    emit_status = STATUS_OK;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
        end
    end

    // Result fields are built from the updated stores.
    always_comb
    begin
        res        = '0;
        res.status = emit_status;
        if (emit_status == STATUS_OK)
        begin
            if (kinds_next[0])
            begin
                res.rate_hz       = si_next[63:44];
                res.channel_count = {1'b0, si_next[43:41]} + 4'd1;
                res.sample_bits   = {1'b0, si_next[40:36]} + 6'd1;
                res.total_samples = si_next[35:0];
            end
            if (pic1_next[31:0] != '0)
            begin
                res.picture_present = 1'b1;
                res.picture_width   = pic0_next[63:32];
                res.picture_height  = pic0_next[31:0];
                res.picture_length  = pic1_next[63:32];
                res.picture_offset  = pic1_next[31:0];
            end
        end
    end

    assign res_valid = step && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            fbi_reg   <= '0;
            bbl_reg   <= '0;
            last_reg  <= 1'b0;
            btype_reg <= '0;
            kinds_reg <= '0;
            la_reg    <= '0;
            skip_reg  <= '0;
            pos_reg   <= '0;
            si_reg    <= '0;
            pic0_reg  <= '0;
            pic1_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            fbi_reg   <= fbi_next;
            bbl_reg   <= bbl_next;
            last_reg  <= last_next;
            btype_reg <= btype_next;
            kinds_reg <= kinds_next;
            la_reg    <= la_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            si_reg    <= si_next;
            pic0_reg  <= pic0_next;
            pic1_reg  <= pic1_next;
        end
    end

endmodule

@@ hdl/flac_mbp_out_stage.sv @@
// Result register of the FLAC metadata parser: holds one summary word.
// Depends on flac_mbp_pkg.
module flac_mbp_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  flac_mbp_pkg::result_t load_word,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output flac_mbp_pkg::result_t out_word
);
    import flac_mbp_pkg::*;

    logic    valid_reg;
    result_t word_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && space)
        begin
            word_reg <= load_word;
        end
    end

endmodule

@@ hdl/flac_metadata_block_parser.sv @@
// FLAC metadata block parser: one stream byte per word in, at most one summary out.
// An accepted word waits in the input register until the result register has space,
// then updates the parser; any summary it causes is registered onto out_valid with it.
// Throughput: one word per cycle while the result register has space for a summary.
// Reset: rst_n clears all parser state and both stage valid flags at once.
// Depends on flac_mbp_pkg, flac_mbp_in_stage, flac_mbp_core, flac_mbp_out_stage.
module flac_metadata_block_parser #(
    parameter int OFFSET_WIDTH = flac_mbp_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [19:0] rate_hz,
    output logic [3:0]  channel_count,
    output logic [5:0]  sample_bits,
    output logic [35:0] total_samples,
    output logic        picture_present,
    output logic [31:0] picture_width,
    output logic [31:0] picture_height,
    output logic [31:0] picture_length,
    output logic [31:0] picture_offset
);
    import flac_mbp_pkg::*;

    in_word_t in_word;
    in_word_t held_word;
    logic     held_valid;
    logic     out_space;
    logic     advance;
    logic     res_valid;
    result_t  res;
    result_t  out_word;

    assign in_word.data_byte     = data_byte;
    assign in_word.end_of_stream = end_of_stream;

    // Advance the held word into the parser whenever the result register can
    // take whatever it produces; a waiting summary stalls only this step.
    assign advance = held_valid && out_space;

    flac_mbp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .held_valid (held_valid),
        .held_word  (held_word),
        .advance    (advance)
    );

    // Walk magic, block headers and the STREAMINFO / PICTURE bodies.
    flac_mbp_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .word      (held_word),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold the summary until the downstream side takes it.
    flac_mbp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_word (res),
        .space     (out_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    assign status          = out_word.status;
    assign rate_hz         = out_word.rate_hz;
    assign channel_count   = out_word.channel_count;
    assign sample_bits     = out_word.sample_bits;
    assign total_samples   = out_word.total_samples;
    assign picture_present = out_word.picture_present;
    assign picture_width   = out_word.picture_width;
    assign picture_height  = out_word.picture_height;
    assign picture_length  = out_word.picture_length;
    assign picture_offset  = out_word.picture_offset;

endmodule
